// ----- sv/assert_macros.svh -----
// Shared assertion macros; the using module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every rising clock edge outside reset.
`define TMH_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define TMH_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tmh_pkg.sv -----
package tmh_pkg;

	localparam int HEAP_DEPTH = 16;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int CW         = IDX_W + 2;
	localparam int TIME_W     = 48;
	localparam int TAG_W      = 8;
	localparam int OCC_W      = 6;
	localparam int FIRE_W     = 6;
	localparam logic [FIRE_W-1:0] MAX_FIRES = 6'd32;

	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_CANCEL  = 2'd1;
	localparam logic [1:0] ACT_SERVICE = 2'd2;
	localparam logic [1:0] ACT_QUERY   = 2'd3;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;
	localparam logic [1:0] KIND_REPORT = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] now;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TAG_W-1:0]  fired_tag;
		logic [TIME_W-1:0] next_timeout;
		logic [OCC_W-1:0]  occupancy;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] interval;
		logic [TAG_W-1:0]  tag;
		logic              canceled;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_ADD_INIT,
		OP_RD_PARENT,
		OP_SU_MOVE,
		OP_WR_CUR,
		OP_RD_C1,
		OP_RD_C2,
		OP_LOAD_A,
		OP_SD_PICK,
		OP_SD_STEP,
		OP_RD_TOP,
		OP_POP,
		OP_FIRE_POP,
		OP_REPEAT,
		OP_LOAD_CUR,
		OP_CAN_RD,
		OP_CAN_WR,
		OP_EMIT_ACK,
		OP_EMIT_REJ,
		OP_EMIT_FIRE,
		OP_EMIT_RPT
	} dp_op_t;

	typedef struct packed {
		logic [1:0] act;
		logic       full;
		logic       empty;
		logic       su_root;
		logic       su_move;
		logic       c1_in;
		logic       c2_in;
		logic       sd_stop;
		logic       can_done;
		logic       top_can;
		logic       top_due;
		logic       top_rep;
		logic       fires_ok;
		logic       out_free;
	} dp_status_t;

endpackage

// ----- sv/tmh_datapath.sv -----
`include "assert_macros.svh"

module tmh_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tmh_pkg::dp_op_t     op,
	output tmh_pkg::dp_status_t status,
	input  tmh_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tmh_pkg::out_item_t  out_item
);

	tmh_pkg::entry_t mem [tmh_pkg::HEAP_DEPTH];

	tmh_pkg::in_item_t                req_q;
	tmh_pkg::entry_t                  rd_q, cur_q, a_q;
	logic [tmh_pkg::IDX_W-1:0]        i_q, m_q;
	logic [tmh_pkg::CNT_W-1:0]        cnt_q, k_q;
	logic [tmh_pkg::FIRE_W-1:0]       fires_q;
	logic [tmh_pkg::TAG_W-1:0]        ftag_q;
	logic                             ovalid_q;
	tmh_pkg::out_item_t               out_q;

	logic [tmh_pkg::CW-1:0]           c1, c2, cnt_w;
	logic [tmh_pkg::IDX_W-1:0]        parent, raddr, waddr;
	logic                             rd_en, we;
	tmh_pkg::entry_t                  wdata;
	logic [tmh_pkg::TIME_W:0]         rsum;
	logic [tmh_pkg::TIME_W-1:0]       rdl, tleft;
	logic                             out_free;
	logic                             emit_op;

	assign c1     = {1'b0, i_q, 1'b1};
	assign c2     = c1 + tmh_pkg::CW'(1);
	assign cnt_w  = tmh_pkg::CW'(cnt_q);
	assign parent = tmh_pkg::IDX_W'((i_q - tmh_pkg::IDX_W'(1)) >> 1);
	assign out_free = !ovalid_q || out_ready;
	assign emit_op = (op == tmh_pkg::OP_EMIT_ACK) || (op == tmh_pkg::OP_EMIT_REJ) ||
	                 (op == tmh_pkg::OP_EMIT_FIRE) || (op == tmh_pkg::OP_EMIT_RPT);

	// Restart deadline, saturating at all ones
	assign rsum = {1'b0, req_q.now} + {1'b0, rd_q.interval};
	assign rdl  = rsum[tmh_pkg::TIME_W] ? '1 : rsum[tmh_pkg::TIME_W-1:0];

	always_comb begin
		if (cnt_q == '0) begin
			tleft = '1;
		end else if (rd_q.deadline > req_q.now) begin
			tleft = rd_q.deadline - req_q.now;
		end else begin
			tleft = '0;
		end
	end

	always_comb begin
		rd_en = 1'b1;
		unique case (op)
			tmh_pkg::OP_RD_PARENT: raddr = parent;
			tmh_pkg::OP_RD_C1:     raddr = c1[tmh_pkg::IDX_W-1:0];
			tmh_pkg::OP_RD_C2:     raddr = c2[tmh_pkg::IDX_W-1:0];
			tmh_pkg::OP_POP,
			tmh_pkg::OP_FIRE_POP:  raddr = tmh_pkg::IDX_W'(cnt_q - tmh_pkg::CNT_W'(1));
			tmh_pkg::OP_CAN_RD:    raddr = k_q[tmh_pkg::IDX_W-1:0];
			tmh_pkg::OP_RD_TOP:    raddr = '0;
			default: begin
				raddr = '0;
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		we    = 1'b1;
		waddr = i_q;
		wdata = cur_q;
		unique case (op)
			tmh_pkg::OP_WR_CUR:  wdata = cur_q;
			tmh_pkg::OP_SU_MOVE: wdata = rd_q;
			tmh_pkg::OP_SD_STEP: wdata = status.sd_stop ? cur_q : a_q;
			tmh_pkg::OP_CAN_WR: begin
				waddr = k_q[tmh_pkg::IDX_W-1:0];
				wdata = rd_q;
				wdata.canceled = 1'b1;
				we = (rd_q.tag == req_q.tag);
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			unique case (op)
				tmh_pkg::OP_ADD_INIT: cnt_q <= cnt_q + tmh_pkg::CNT_W'(1);
				tmh_pkg::OP_POP,
				tmh_pkg::OP_FIRE_POP: cnt_q <= cnt_q - tmh_pkg::CNT_W'(1);
				default: ;
			endcase
			if (emit_op) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			tmh_pkg::OP_LATCH: begin
				req_q   <= in_item;
				k_q     <= '0;
				fires_q <= '0;
			end
			tmh_pkg::OP_ADD_INIT: begin
				cur_q <= '{deadline: req_q.deadline, interval: req_q.interval,
				           tag: req_q.tag, canceled: 1'b0};
				i_q   <= cnt_q[tmh_pkg::IDX_W-1:0];
			end
			tmh_pkg::OP_SU_MOVE: i_q <= parent;
			tmh_pkg::OP_RD_C2: begin
				a_q <= rd_q;
				m_q <= c1[tmh_pkg::IDX_W-1:0];
			end
			tmh_pkg::OP_LOAD_A: begin
				a_q <= rd_q;
				m_q <= c1[tmh_pkg::IDX_W-1:0];
			end
			tmh_pkg::OP_SD_PICK: begin
				// ties go to the right child
				if (!(a_q.deadline < rd_q.deadline)) begin
					a_q <= rd_q;
					m_q <= c2[tmh_pkg::IDX_W-1:0];
				end
			end
			tmh_pkg::OP_SD_STEP: begin
				if (!status.sd_stop) begin
					i_q <= m_q;
				end
			end
			tmh_pkg::OP_POP: i_q <= '0;
			tmh_pkg::OP_FIRE_POP: begin
				i_q     <= '0;
				ftag_q  <= rd_q.tag;
				fires_q <= fires_q + tmh_pkg::FIRE_W'(1);
			end
			tmh_pkg::OP_REPEAT: begin
				cur_q   <= '{deadline: rdl, interval: rd_q.interval,
				            tag: rd_q.tag, canceled: rd_q.canceled};
				i_q     <= '0;
				ftag_q  <= rd_q.tag;
				fires_q <= fires_q + tmh_pkg::FIRE_W'(1);
			end
			tmh_pkg::OP_LOAD_CUR: cur_q <= rd_q;
			tmh_pkg::OP_CAN_WR:   k_q <= k_q + tmh_pkg::CNT_W'(1);
			tmh_pkg::OP_EMIT_ACK: out_q <= '{kind: tmh_pkg::KIND_ACK, fired_tag: '0,
				next_timeout: '0, occupancy: tmh_pkg::OCC_W'(cnt_q), last: 1'b1};
			tmh_pkg::OP_EMIT_REJ: out_q <= '{kind: tmh_pkg::KIND_REJECT, fired_tag: '0,
				next_timeout: '0, occupancy: tmh_pkg::OCC_W'(cnt_q), last: 1'b1};
			tmh_pkg::OP_EMIT_FIRE: out_q <= '{kind: tmh_pkg::KIND_FIRED, fired_tag: ftag_q,
				next_timeout: '0, occupancy: tmh_pkg::OCC_W'(cnt_q), last: 1'b0};
			tmh_pkg::OP_EMIT_RPT: out_q <= '{kind: tmh_pkg::KIND_REPORT, fired_tag: '0,
				next_timeout: tleft, occupancy: tmh_pkg::OCC_W'(cnt_q), last: 1'b1};
			default: ;
		endcase
	end

	assign status.act      = req_q.action;
	assign status.full     = (cnt_q == tmh_pkg::CNT_W'(tmh_pkg::HEAP_DEPTH));
	assign status.empty    = (cnt_q == '0);
	assign status.su_root  = (i_q == '0);
	assign status.su_move  = (cur_q.deadline < rd_q.deadline);
	assign status.c1_in    = (c1 < cnt_w);
	assign status.c2_in    = (c2 < cnt_w);
	assign status.sd_stop  = (cur_q.deadline <= a_q.deadline);
	assign status.can_done = (k_q >= cnt_q);
	assign status.top_can  = rd_q.canceled;
	assign status.top_due  = (rd_q.deadline <= req_q.now);
	assign status.top_rep  = (rd_q.interval != '0);
	assign status.fires_ok = (fires_q < tmh_pkg::MAX_FIRES);
	assign status.out_free = out_free;

	assign out_valid = ovalid_q;
	assign out_item  = out_q;

	`TMH_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= tmh_pkg::CNT_W'(tmh_pkg::HEAP_DEPTH), "heap count over depth")
	`TMH_ASSERT_ALWAYS(a_emit_free, !emit_op || out_free, "result overwritten")
	`TMH_ASSERT_NEXT(a_add_cnt, op == tmh_pkg::OP_ADD_INIT, cnt_q == $past(cnt_q) + tmh_pkg::CNT_W'(1), "add did not grow heap")

endmodule

// ----- sv/tmh_ctrl.sv -----
module tmh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tmh_pkg::dp_status_t status,
	output tmh_pkg::dp_op_t     op
);

	typedef enum logic [16:0] {
		S_IDLE      = 17'h00001,
		S_DISPATCH  = 17'h00002,
		S_SU        = 17'h00004,
		S_SU_CMP    = 17'h00008,
		S_ACK       = 17'h00010,
		S_REJ       = 17'h00020,
		S_CAN_RD    = 17'h00040,
		S_CAN_WR    = 17'h00080,
		S_SV_RD     = 17'h00100,
		S_SV_DEC    = 17'h00200,
		S_POP_LD    = 17'h00400,
		S_SD_C1     = 17'h00800,
		S_SD_C2     = 17'h01000,
		S_SD_ONE    = 17'h02000,
		S_SD_PICK   = 17'h04000,
		S_SD_CMP    = 17'h08000,
		S_REPORT    = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic   fire_q, fire_d, emit_fire_q, emit_fire_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		fire_d      = fire_q;
		emit_fire_d = emit_fire_q;
		op          = tmh_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = tmh_pkg::OP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (status.act)
					tmh_pkg::ACT_ADD: begin
						if (status.full) begin
							state_d = S_REJ;
						end else begin
							op      = tmh_pkg::OP_ADD_INIT;
							state_d = S_SU;
						end
					end
					tmh_pkg::ACT_CANCEL:  state_d = S_CAN_RD;
					tmh_pkg::ACT_SERVICE: state_d = S_SV_RD;
					default: begin
						op      = tmh_pkg::OP_RD_TOP;
						state_d = S_REPORT;
					end
				endcase
			end
			S_SU: begin
				if (status.su_root) begin
					op      = tmh_pkg::OP_WR_CUR;
					state_d = S_ACK;
				end else begin
					op      = tmh_pkg::OP_RD_PARENT;
					state_d = S_SU_CMP;
				end
			end
			S_SU_CMP: begin
				if (status.su_move) begin
					op      = tmh_pkg::OP_SU_MOVE;
					state_d = S_SU;
				end else begin
					op      = tmh_pkg::OP_WR_CUR;
					state_d = S_ACK;
				end
			end
			S_ACK: begin
				if (status.out_free) begin
					op      = tmh_pkg::OP_EMIT_ACK;
					state_d = S_IDLE;
				end
			end
			S_REJ: begin
				if (status.out_free) begin
					op      = tmh_pkg::OP_EMIT_REJ;
					state_d = S_IDLE;
				end
			end
			S_CAN_RD: begin
				if (status.can_done) begin
					state_d = S_ACK;
				end else begin
					op      = tmh_pkg::OP_CAN_RD;
					state_d = S_CAN_WR;
				end
			end
			S_CAN_WR: begin
				op      = tmh_pkg::OP_CAN_WR;
				state_d = S_CAN_RD;
			end
			S_SV_RD: begin
				// a pending fire goes out once its sift is done
				if (emit_fire_q) begin
					if (status.out_free) begin
						op          = tmh_pkg::OP_EMIT_FIRE;
						emit_fire_d = 1'b0;
					end
				end else if (status.empty) begin
					state_d = S_REPORT;
				end else begin
					op      = tmh_pkg::OP_RD_TOP;
					state_d = S_SV_DEC;
				end
			end
			S_SV_DEC: begin
				if (status.top_can) begin
					op      = tmh_pkg::OP_POP;
					fire_d  = 1'b0;
					state_d = S_POP_LD;
				end else if (status.top_due && status.fires_ok) begin
					fire_d = 1'b1;
					if (status.top_rep) begin
						op      = tmh_pkg::OP_REPEAT;
						state_d = S_SD_C1;
					end else begin
						op      = tmh_pkg::OP_FIRE_POP;
						state_d = S_POP_LD;
					end
				end else begin
					state_d = S_REPORT;
				end
			end
			S_POP_LD: begin
				op      = tmh_pkg::OP_LOAD_CUR;
				state_d = S_SD_C1;
			end
			S_SD_C1: begin
				if (!status.c1_in) begin
					op          = tmh_pkg::OP_WR_CUR;
					emit_fire_d = fire_q;
					state_d     = S_SV_RD;
				end else begin
					op      = tmh_pkg::OP_RD_C1;
					state_d = status.c2_in ? S_SD_C2 : S_SD_ONE;
				end
			end
			S_SD_C2: begin
				op      = tmh_pkg::OP_RD_C2;
				state_d = S_SD_PICK;
			end
			S_SD_ONE: begin
				op      = tmh_pkg::OP_LOAD_A;
				state_d = S_SD_CMP;
			end
			S_SD_PICK: begin
				op      = tmh_pkg::OP_SD_PICK;
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				op = tmh_pkg::OP_SD_STEP;
				if (status.sd_stop) begin
					emit_fire_d = fire_q;
					state_d     = S_SV_RD;
				end else begin
					state_d = S_SD_C1;
				end
			end
			S_REPORT: begin
				if (status.out_free) begin
					op      = tmh_pkg::OP_EMIT_RPT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fire_q      <= 1'b0;
			emit_fire_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fire_q      <= fire_d;
			emit_fire_q <= emit_fire_d;
		end
	end

endmodule

// ----- sv/timer_min_heap_scheduler.sv -----
// channel | handshake             | payload
// in      | in_valid / in_ready   | in_item  (action, tag, deadline, interval, now)
// out     | out_valid / out_ready | out_item (kind, fired_tag, next_timeout, occupancy, last)
// One request at a time; in_ready is high only while the controller is idle.
// Add: the new entry moves up one level per parent compare until it stops or reaches the root.
// Cancel: reads every entry in turn and marks those with a matching tag; query reads the top entry.
// Each service fire or drop sifts down one level at a time through the one RAM read port.
// A stalled output holds the controller before it writes the next result.
// Reset clears the entry count; heap contents need no clearing pass.
module timer_min_heap_scheduler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tmh_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tmh_pkg::out_item_t  out_item
);

	tmh_pkg::dp_op_t     op;
	tmh_pkg::dp_status_t status;

	tmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.op       (op)
	);

	tmh_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.status    (status),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int                TIME_W = tmh_pkg::TIME_W;
	localparam int                TAG_W = tmh_pkg::TAG_W;
	localparam int                OCC_W = tmh_pkg::OCC_W;
	localparam int                HEAP_DEPTH = tmh_pkg::HEAP_DEPTH;
	localparam logic [TIME_W-1:0] TIME_ONES = {TIME_W{1'b1}};
	localparam int                CYCLE_LIMIT = 1500000;
	localparam int                FIRE_CAP = 32;
	localparam int                HOLD_CYCLES = 400;

	typedef struct {
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] interval;
		logic [TAG_W-1:0]  tag;
		logic              canceled;
	} timer_t;

	typedef struct {
		tmh_pkg::in_item_t  req;
		logic               fixed;
		tmh_pkg::out_item_t resp;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	tmh_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	tmh_pkg::out_item_t out_item;

	timer_t             heap_q[HEAP_DEPTH];
	int                 heap_count;
	tmh_pkg::out_item_t pending_q[$];
	int                 errors = 0;
	int                 cycles = 0;
	int                 stall_pct;
	int                 hold_off;
	logic               hold_kick;
	logic               hold_seen_q;
	stim_row_t          rows[$];

	timer_min_heap_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void queue_result(input tmh_pkg::out_item_t r);
		pending_q.insert(pending_q.size(), r);
	endfunction

	function automatic void swap_timers(input int a, input int b);
		timer_t t;
		t = heap_q[a];
		heap_q[a] = heap_q[b];
		heap_q[b] = t;
	endfunction

	function automatic void sift_up(input int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!(heap_q[i].deadline < heap_q[p].deadline))
				break;
			swap_timers(i, p);
			i = p;
		end
	endfunction

	function automatic void sift_down(input int i);
		int c;
		int m;
		forever begin
			c = 2 * i + 1;
			if (c >= heap_count)
				break;
			m = c;
			if (c + 1 < heap_count)
				m = (heap_q[c].deadline < heap_q[c + 1].deadline) ? c : c + 1;
			if (heap_q[i].deadline <= heap_q[m].deadline)
				break;
			swap_timers(i, m);
			i = m;
		end
	endfunction

	function automatic void pop_top();
		if (heap_count == 0)
			return;
		swap_timers(0, heap_count - 1);
		heap_count--;
		sift_down(0);
	endfunction

	function automatic tmh_pkg::out_item_t make_resp(input logic [1:0] k,
			input logic [TAG_W-1:0] t, input logic [TIME_W-1:0] tmo, input logic lst);
		tmh_pkg::out_item_t r;
		r.kind = k;
		r.fired_tag = t;
		r.next_timeout = tmo;
		r.occupancy = OCC_W'(heap_count);
		r.last = lst;
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] time_left(input logic [TIME_W-1:0] now);
		if (heap_count == 0)
			return TIME_ONES;
		return (heap_q[0].deadline > now) ? heap_q[0].deadline - now : '0;
	endfunction

	// Append the results that one request causes to the pending queue.
	function automatic void predict_timers(input tmh_pkg::in_item_t r);
		int fires;
		logic [TAG_W-1:0] t;
		logic [TIME_W:0] nd;
		fires = 0;
		case (r.action)
			tmh_pkg::ACT_ADD: begin
				if (heap_count >= HEAP_DEPTH) begin
					queue_result(make_resp(tmh_pkg::KIND_REJECT, '0, '0, 1'b1));
				end else begin
					heap_q[heap_count].deadline = r.deadline;
					heap_q[heap_count].interval = r.interval;
					heap_q[heap_count].tag = r.tag;
					heap_q[heap_count].canceled = 1'b0;
					heap_count++;
					sift_up(heap_count - 1);
					queue_result(make_resp(tmh_pkg::KIND_ACK, '0, '0, 1'b1));
				end
			end
			tmh_pkg::ACT_CANCEL: begin
				for (int i = 0; i < heap_count; i++)
					if (heap_q[i].tag == r.tag)
						heap_q[i].canceled = 1'b1;
				queue_result(make_resp(tmh_pkg::KIND_ACK, '0, '0, 1'b1));
			end
			tmh_pkg::ACT_SERVICE: begin
				while (heap_count > 0) begin
					if (heap_q[0].canceled) begin
						pop_top();
					end else if (heap_q[0].deadline <= r.now && fires < FIRE_CAP) begin
						t = heap_q[0].tag;
						fires++;
						if (heap_q[0].interval != 0) begin
							nd = {1'b0, r.now} + {1'b0, heap_q[0].interval};
							heap_q[0].deadline = nd[TIME_W] ? TIME_ONES : nd[TIME_W-1:0];
							sift_down(0);
						end else begin
							pop_top();
						end
						queue_result(make_resp(tmh_pkg::KIND_FIRED, t, '0, 1'b0));
					end else begin
						break;
					end
				end
				queue_result(make_resp(tmh_pkg::KIND_REPORT, '0, time_left(r.now), 1'b1));
			end
			default: queue_result(make_resp(tmh_pkg::KIND_REPORT, '0, time_left(r.now), 1'b1));
		endcase
	endfunction

	function automatic tmh_pkg::in_item_t make_req(input logic [1:0] a,
			input logic [TAG_W-1:0] t, input logic [TIME_W-1:0] d,
			input logic [TIME_W-1:0] iv, input logic [TIME_W-1:0] n);
		tmh_pkg::in_item_t r;
		r.action = a;
		r.tag = t;
		r.deadline = d;
		r.interval = iv;
		r.now = n;
		return r;
	endfunction

	function automatic void add_row(input tmh_pkg::in_item_t r, input logic fx,
			input logic [1:0] k, input logic [TIME_W-1:0] tmo, input int occ);
		stim_row_t s;
		s.req = r;
		s.fixed = fx;
		s.resp.kind = k;
		s.resp.fired_tag = '0;
		s.resp.next_timeout = tmo;
		s.resp.occupancy = OCC_W'(occ);
		s.resp.last = 1'b1;
		rows.insert(rows.size(), s);
	endfunction

	function automatic logic [TIME_W-1:0] rand_wide();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [TIME_W-1:0] v;
		v = rand_wide();
		case ($urandom_range(0, 3))
			0: return v;
			1: return TIME_ONES - TIME_W'($urandom_range(0, 50));
			default: return TIME_W'($urandom_range(0, 400));
		endcase
	endfunction

	function automatic tmh_pkg::in_item_t rand_req(input logic [TIME_W-1:0] base);
		logic [1:0] a;
		int p;
		p = $urandom_range(0, 99);
		a = (p < 45) ? tmh_pkg::ACT_ADD : (p < 55) ? tmh_pkg::ACT_CANCEL :
			(p < 90) ? tmh_pkg::ACT_SERVICE : tmh_pkg::ACT_QUERY;
		if ($urandom_range(0, 9) == 0)
			return make_req(a, TAG_W'($urandom), rand_wide(), rand_time(), rand_wide());
		return make_req(a, TAG_W'($urandom_range(0, 15)),
			base + TIME_W'($urandom_range(0, 300)),
			($urandom_range(0, 2) == 0) ? '0 : rand_time(),
			base + TIME_W'($urandom_range(0, 300)));
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_req(input tmh_pkg::in_item_t r);
		while ($urandom_range(1, 100) <= stall_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_timers(r);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	// Receiver stall percentage per phase.
	int idle_rx;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off <= 0;
			hold_seen_q <= hold_kick;
		end else if (hold_kick != hold_seen_q) begin
			hold_seen_q <= hold_kick;
			hold_off <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= ($urandom_range(1, 100) > idle_rx);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result kind=%0d", out_item.kind);
				errors++;
			end else begin
				tmh_pkg::out_item_t e;
				e = pending_q.pop_front();
				if (out_item.kind !== e.kind) begin
					$error("kind expected %0d got %0d", e.kind, out_item.kind);
					errors++;
				end
				if (out_item.fired_tag !== e.fired_tag) begin
					$error("fired_tag expected %0d got %0d", e.fired_tag, out_item.fired_tag);
					errors++;
				end
				if (out_item.next_timeout !== e.next_timeout) begin
					$error("next_timeout expected %0h got %0h", e.next_timeout,
						out_item.next_timeout);
					errors++;
				end
				if (out_item.occupancy !== e.occupancy) begin
					$error("occupancy expected %0d got %0d", e.occupancy, out_item.occupancy);
					errors++;
				end
				if (out_item.last !== e.last) begin
					$error("last expected %0d got %0d", e.last, out_item.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [TIME_W-1:0] base;
		tmh_pkg::in_item_t r;
		heap_count = 0;
		stall_pct = 0;
		idle_rx = 0;
		hold_kick = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;

		// directed rows: fixed ones carry an expected value readable at a glance
		add_row(make_req(tmh_pkg::ACT_QUERY, '0, '0, '0, '0), 1, tmh_pkg::KIND_REPORT,
			TIME_ONES, 0);
		add_row(make_req(tmh_pkg::ACT_SERVICE, '0, '0, '0, TIME_ONES), 1,
			tmh_pkg::KIND_REPORT, TIME_ONES, 0);
		add_row(make_req(tmh_pkg::ACT_CANCEL, 8'hFF, '0, '0, '0), 1, tmh_pkg::KIND_ACK, '0, 0);
		for (int i = 0; i < HEAP_DEPTH; i++)
			add_row(make_req(tmh_pkg::ACT_ADD, TAG_W'(i == 0 ? 8'hFF : i),
				(i == 1) ? TIME_ONES : TIME_W'(100 + (i % 4)),
				(i == 2) ? TIME_ONES : (i == 3) ? '0 : TIME_W'(10), '0),
				1, tmh_pkg::KIND_ACK, '0, i + 1);
		add_row(make_req(tmh_pkg::ACT_ADD, 8'h55, '0, '0, '0), 1, tmh_pkg::KIND_REJECT, '0,
			HEAP_DEPTH);
		add_row(make_req(tmh_pkg::ACT_CANCEL, 8'h04, '0, '0, '0), 0, '0, '0, 0);
		add_row(make_req(tmh_pkg::ACT_QUERY, '0, '0, '0, TIME_W'(50)), 0, '0, '0, 0);
		add_row(make_req(tmh_pkg::ACT_SERVICE, '0, '0, '0, TIME_W'(101)), 0, '0, '0, 0);
		add_row(make_req(tmh_pkg::ACT_SERVICE, '0, '0, '0, TIME_ONES), 0, '0, '0, 0);
		add_row(make_req(tmh_pkg::ACT_SERVICE, '0, '0, '0, TIME_ONES), 0, '0, '0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_req(rows[i].req);
			if (rows[i].fixed) begin
				pending_q.delete(pending_q.size() - 1);
				queue_result(rows[i].resp);
			end
		end
		wait_drained();

		// random phases
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin stall_pct = 0; idle_rx = 0; end
				1: begin stall_pct = 72; idle_rx = 0; end
				2: begin stall_pct = 0; idle_rx = 72; end
				3: begin stall_pct = 28; idle_rx = 28; end
				default: begin stall_pct = 0; idle_rx = 0; end
			endcase
			if (ph == 4) begin
				@(negedge clk);
				hold_kick = ~hold_kick;
			end
			base = rand_wide() >> 1;
			for (int n = 0; n < 90; n++) begin
				r = rand_req(base);
				send_req(r);
				if (r.action == tmh_pkg::ACT_SERVICE)
					base = r.now;
				if (n == 45)
					wait_drained();
			end
			wait_drained();
		end

		repeat (200) @(negedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/tmh_pkg.sv
sv/tmh_datapath.sv
sv/tmh_ctrl.sv
sv/timer_min_heap_scheduler.sv
sim/testbench.sv
